// ===== sv/pss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Shared widths, register codes, reset values and sequencer states of the
// physics substep scheduler.
// ----------------------------------------------------------------------------
package pss_pkg;

    // Time values: unsigned, 24 fractional bits of seconds.
    localparam int TimeW   = 25;
    localparam int FracW   = 16;
    localparam int SumW    = TimeW + 1;
    localparam int DivNumW = TimeW + FracW;
    localparam int DivDenW = TimeW + 1;

    localparam int DefMaxSteps = 64;

    // Configuration register indexes.
    localparam logic [1:0] RegChange = 2'd0;
    localparam logic [1:0] RegLead   = 2'd1;
    localparam logic [1:0] RegMax    = 2'd2;

    localparam logic [FracW-1:0] ChangeRst = 16'd1311;
    localparam logic [TimeW-1:0] LeadRst   = 25'd50332;
    localparam logic [TimeW-1:0] MaxRst    = 25'd671089;

    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

    // Division by five as a reciprocal multiply: ceil(2^27 / 5), exact for
    // every 25-bit dividend.
    localparam logic [TimeW-1:0] FifthMul   = 25'd26843546;
    localparam int               FifthShift = 27;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_W,
        ST_CHECK,
        ST_DIV_MIN,
        ST_DIV_MAX,
        ST_LEAD,
        ST_STEP,
        ST_DIV_MOD,
        ST_UPDATE,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== sv/pss_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pss_div
// Restoring divider, one quotient bit per cycle, shared by every division of
// the scheduler.
// ----------------------------------------------------------------------------
module pss_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pss_pkg::DivNumW-1:0] i_dividend,
    input  wire logic [pss_pkg::DivDenW-1:0] i_divisor,
    output logic                             o_done,
    output logic [pss_pkg::DivNumW-1:0]      o_quot,
    output logic [pss_pkg::DivDenW-1:0]      o_rem
);

    localparam int CntW = $clog2(pss_pkg::DivNumW + 1);
    localparam logic [CntW-1:0] LastCnt = CntW'(pss_pkg::DivNumW - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CntW-1:0]              r_cnt;
    logic [pss_pkg::DivDenW-1:0]  r_den;
    logic [pss_pkg::DivDenW-1:0]  r_rem;
    logic [pss_pkg::DivNumW-1:0]  r_quo;
    logic [pss_pkg::DivDenW:0]    trial;
    logic                         fits;

    // Bring down the next dividend bit and try to subtract.
    assign trial = {r_rem, r_quo[pss_pkg::DivNumW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastCnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= pss_pkg::DivDenW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[pss_pkg::DivDenW-1:0];
            end
            r_quo <= {r_quo[pss_pkg::DivNumW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== sv/physics_substep_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// physics_substep_scheduler
// Splits one rendered frame into simulation steps: even split of long frames,
// ramping toward the wanted step, or phase nudging toward a target lead.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                 Payload
//  s_*      in   s_tvalid / s_tready       frame, simulated time, previous step
//  m_*      out  m_tvalid / m_tready       step length, tlast, tuser=truncated
//  APB      in   psel & penable & pwrite   max_change_fraction, lead, max_step
//
// One item is taken at a time; s_tready is high only while idle.
// Setup costs up to four divisions on the shared divider; each phase-mode
// step with a nonzero step costs one more division and then passes through
// the update and output states. Ramp-mode steps need no division and go
// from the step state through update to output. Output stalls hold the
// sequencer in place. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module physics_substep_scheduler #(
    parameter int MAX_STEPS = pss_pkg::DefMaxSteps
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input item.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [24:0] frame_time, [49:25] simulated_time, [74:50] previous_step
    input  wire logic [79:0] s_tdata,
    // Result item.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [24:0] step_length
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    // [0] truncated
    output logic             m_tuser,
    // Configuration.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int TW   = pss_pkg::TimeW;
    localparam int FW   = pss_pkg::FracW;
    localparam int SW   = pss_pkg::SumW;
    localparam int NW   = pss_pkg::DivNumW;
    localparam int DW   = pss_pkg::DivDenW;
    localparam int CntW = $clog2(MAX_STEPS + 1);
    localparam logic [CntW-1:0] StepCap = CntW'(MAX_STEPS);

    // Configuration registers.
    logic [FW-1:0] r_change;
    logic [TW-1:0] r_lead_cfg;
    logic [TW-1:0] r_max;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_change   <= pss_pkg::ChangeRst;
            r_lead_cfg <= pss_pkg::LeadRst;
            r_max      <= pss_pkg::MaxRst;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pss_pkg::RegChange: r_change   <= pwdata[FW-1:0];
                pss_pkg::RegLead:   r_lead_cfg <= pwdata[TW-1:0];
                pss_pkg::RegMax:    r_max      <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pss_pkg::RegChange: prdata = {{(32-FW){1'b0}}, r_change};
            pss_pkg::RegLead:   prdata = {{(32-TW){1'b0}}, r_lead_cfg};
            pss_pkg::RegMax:    prdata = {{(32-TW){1'b0}}, r_max};
            default:            prdata = '0;
        endcase
    end

    // Sequencer and working registers.
    pss_pkg::t_state r_state, n_state;
    logic [TW-1:0]   r_f, n_f;
    logic [TW-1:0]   r_a, n_a;
    logic [TW-1:0]   r_l, n_l;
    logic [TW-1:0]   r_w, n_w;
    logic [SW-1:0]   r_q1, n_q1;
    logic [TW-1:0]   r_wmin, n_wmin;
    logic [TW-1:0]   r_wmax, n_wmax;
    logic [TW-1:0]   r_lead, n_lead;
    logic            r_ramp, n_ramp;
    logic [TW-1:0]   r_s, n_s;
    logic [SW-1:0]   r_t, n_t;
    logic [TW-1:0]   r_r, n_r;
    logic [CntW-1:0] r_n, n_n;
    logic            r_last, n_last;
    logic            r_trunc, n_trunc;
    logic            r_run, n_run;

    // Shared divider.
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [NW-1:0] div_quot;
    logic [DW-1:0] div_rem;

    pss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Shared multiplier: change of a step, floor(x * c / 2^16).
    logic [TW-1:0]    mul_a;
    logic [TW+FW-1:0] prod;
    logic [TW-1:0]    cs;

    assign mul_a = (r_state == pss_pkg::ST_CHECK) ? r_l : r_s;
    assign prod  = mul_a * r_change;
    assign cs    = prod[TW+FW-1:FW];

    // One fifth of the wanted step by reciprocal multiplication.
    logic [2*TW-1:0] fifth_prod;
    logic [TW-1:0]   fifth;

    assign fifth_prod = r_w * pss_pkg::FifthMul;
    assign fifth      = TW'(fifth_prod >> pss_pkg::FifthShift);

    logic [TW-1:0] mx;
    logic [TW-1:0] diff;
    logic [TW-1:0] e;
    logic [TW-1:0] up;
    logic [TW-1:0] half;
    logic [SW-1:0] sum_up;
    logic [TW-1:0] s_new;
    logic [SW-1:0] t_new;
    logic [CntW-1:0] n_cnt;
    logic [SW-1:0] tts;
    logic [TW-1:0] dn_amt;
    logic [TW-1:0] up_amt;
    logic [TW-1:0] s_dn;
    logic [SW-1:0] s_up;

    assign mx   = (r_max == '0) ? TW'(1) : r_max;
    assign diff = (r_w > r_l) ? (r_w - r_l) : (r_l - r_w);
    assign half = r_lead >> 1;
    assign e    = (r_r == '0) ? '0 : (r_s - r_r);
    assign up   = r_s - e;
    assign tts  = SW'({1'b0, r_f} - r_t + {1'b0, r_lead});

    // Step update candidates.
    assign sum_up = {1'b0, r_s} + {1'b0, cs};
    assign dn_amt = (e < cs) ? e : cs;
    assign up_amt = (up < cs) ? up : cs;
    assign s_dn   = r_s - dn_amt;
    assign s_up   = {1'b0, r_s} + {1'b0, up_amt};

    always_comb begin
        s_new = r_s;
        if (r_ramp) begin
            if (r_w > r_s) begin
                s_new = (sum_up < {1'b0, r_w}) ? sum_up[TW-1:0] : r_w;
            end else begin
                s_new = ((r_s - cs) > r_w) ? (r_s - cs) : r_w;
            end
        end else if ({1'b0, e} < ({1'b0, r_s} - {1'b0, e})) begin
            if (e > half) begin
                s_new = (s_dn > r_wmin) ? s_dn : r_wmin;
            end
        end else if (up > half) begin
            s_new = (s_up < {1'b0, r_wmax}) ? s_up[TW-1:0] : r_wmax;
        end
    end

    assign t_new = r_t + {1'b0, s_new};
    assign n_cnt = r_n + 1'b1;

    // Divider operands by sequencer state.
    always_comb begin
        div_num = {{(NW-TW){1'b0}}, r_f};
        div_den = {1'b0, mx};
        unique case (r_state)
            pss_pkg::ST_DIV_W: begin
                div_den = r_q1;
            end
            pss_pkg::ST_DIV_MIN: begin
                div_num = {r_w, {FW{1'b0}}};
                div_den = DW'({1'b1, r_change});
            end
            pss_pkg::ST_DIV_MAX: begin
                div_num = {r_w, {FW{1'b0}}};
                div_den = DW'({1'b1, {FW{1'b0}}} - {1'b0, r_change});
            end
            pss_pkg::ST_DIV_MOD: begin
                div_num = {{(NW-SW){1'b0}}, tts};
                div_den = {1'b0, r_s};
            end
            default: ;
        endcase
    end

    // Next state and working values.
    always_comb begin
        n_state = r_state;
        n_f = r_f; n_a = r_a; n_l = r_l; n_w = r_w; n_q1 = r_q1;
        n_wmin = r_wmin; n_wmax = r_wmax; n_lead = r_lead; n_ramp = r_ramp;
        n_s = r_s; n_t = r_t; n_r = r_r; n_n = r_n;
        n_last = r_last; n_trunc = r_trunc; n_run = r_run;
        div_start = 1'b0;

        unique case (r_state)
            pss_pkg::ST_DIV_Q, pss_pkg::ST_DIV_W, pss_pkg::ST_DIV_MIN,
            pss_pkg::ST_DIV_MAX, pss_pkg::ST_DIV_MOD: begin
                div_start = !r_run;
                if (!r_run) begin
                    n_run = 1'b1;
                end
            end
            default: ;
        endcase
        if (div_done) begin
            n_run = 1'b0;
        end

        unique case (r_state)
            pss_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_f = s_tdata[TW-1:0];
                    n_a = s_tdata[2*TW-1:TW];
                    n_l = s_tdata[3*TW-1:2*TW];
                    n_w = s_tdata[TW-1:0];
                    if (s_tdata[TW-1:0] < s_tdata[2*TW-1:TW]) begin
                        n_state = pss_pkg::ST_IDLE;
                    end else if (s_tdata[TW-1:0] > mx) begin
                        n_state = pss_pkg::ST_DIV_Q;
                    end else begin
                        n_state = pss_pkg::ST_CHECK;
                    end
                end
            end
            pss_pkg::ST_DIV_Q: begin
                if (div_done) begin
                    n_q1    = div_quot[SW-1:0] + 1'b1;
                    n_state = pss_pkg::ST_DIV_W;
                end
            end
            pss_pkg::ST_DIV_W: begin
                if (div_done) begin
                    n_w     = div_quot[TW-1:0];
                    n_state = pss_pkg::ST_CHECK;
                end
            end
            pss_pkg::ST_CHECK: begin
                n_ramp = diff > cs;
                n_s    = r_l;
                n_t    = {1'b0, r_a};
                n_n    = '0;
                n_lead = '0;
                n_state = (diff > cs) ? pss_pkg::ST_STEP : pss_pkg::ST_DIV_MIN;
            end
            pss_pkg::ST_DIV_MIN: begin
                if (div_done) begin
                    n_wmin  = div_quot[TW-1:0];
                    n_state = pss_pkg::ST_DIV_MAX;
                end
            end
            pss_pkg::ST_DIV_MAX: begin
                if (div_done) begin
                    n_wmax  = (div_quot > {{(NW-TW){1'b0}}, pss_pkg::TimeMax}) ?
                              pss_pkg::TimeMax : div_quot[TW-1:0];
                    n_state = pss_pkg::ST_LEAD;
                end
            end
            pss_pkg::ST_LEAD: begin
                n_lead  = (fifth < r_lead_cfg) ? fifth : r_lead_cfg;
                n_state = pss_pkg::ST_STEP;
            end
            pss_pkg::ST_STEP: begin
                n_r = '0;
                if (r_ramp || r_s == '0) begin
                    n_state = pss_pkg::ST_UPDATE;
                end else begin
                    n_state = pss_pkg::ST_DIV_MOD;
                end
            end
            pss_pkg::ST_DIV_MOD: begin
                if (div_done) begin
                    n_r     = div_rem[TW-1:0];
                    n_state = pss_pkg::ST_UPDATE;
                end
            end
            pss_pkg::ST_UPDATE: begin
                n_s     = s_new;
                n_t     = t_new;
                n_n     = n_cnt;
                n_last  = !((t_new <= {1'b0, r_f}) && (n_cnt < StepCap));
                n_trunc = t_new <= {1'b0, r_f};
                n_state = pss_pkg::ST_OUT;
            end
            pss_pkg::ST_OUT: begin
                if (m_tready) begin
                    n_state = r_last ? pss_pkg::ST_IDLE : pss_pkg::ST_STEP;
                end
            end
            default: n_state = pss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pss_pkg::ST_IDLE;
            r_run   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f; r_a <= n_a; r_l <= n_l; r_w <= n_w; r_q1 <= n_q1;
        r_wmin <= n_wmin; r_wmax <= n_wmax; r_lead <= n_lead; r_ramp <= n_ramp;
        r_s <= n_s; r_t <= n_t; r_r <= n_r; r_n <= n_n;
        r_last <= n_last; r_trunc <= n_trunc;
    end

    // Ports.
    assign s_tready = (r_state == pss_pkg::ST_IDLE);
    assign m_tvalid = (r_state == pss_pkg::ST_OUT);
    assign m_tdata  = {{(32-TW){1'b0}}, r_s};
    assign m_tlast  = r_last;
    assign m_tuser  = r_last & r_trunc;

endmodule
`default_nettype wire

// ===== tb/sv/physics_substep_scheduler_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// physics_substep_scheduler_test
// Self-checking bench for the substep scheduler. Frame items go in on the
// input stream, and an in-bench model predicts the step sequence of each one.
// Every result item is compared with the oldest predicted step. The run walks
// a directed table, a step cap case, then random frames under several
// register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module physics_substep_scheduler_test;

    localparam int TimeW      = pss_pkg::TimeW;
    localparam int NumRandom  = 125;
    localparam int WatchLimit = 20000;
    localparam int MaxSteps   = pss_pkg::DefMaxSteps;
    localparam logic [63:0] TimeMask = 64'h1FF_FFFF;
    localparam logic [TimeW-1:0] TimeMax = pss_pkg::TimeMax;
    localparam logic [1:0] RegChange = pss_pkg::RegChange;
    localparam logic [1:0] RegLead   = pss_pkg::RegLead;
    localparam logic [1:0] RegMax    = pss_pkg::RegMax;

    typedef struct packed {
        logic [TimeW-1:0] step;
        logic             last;
        logic             trunc;
    } t_step_item;

    typedef struct {
        logic [TimeW-1:0] frame;
        logic [TimeW-1:0] done_time;
        logic [TimeW-1:0] prev;
        int               fixed_n;     // -1: check against the model only
        logic [TimeW-1:0] fixed_step;
        logic             fixed_trunc;
    } t_frame_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model copy of the registers.
    logic [63:0] cfg_change;
    logic [63:0] cfg_lead;
    logic [63:0] cfg_max;

    t_step_item step_queue[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   hold_off = 1'b0;
    bit   stim_done = 1'b0;

    physics_substep_scheduler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] step_change(logic [63:0] s);
        return (s * cfg_change) >> 16;
    endfunction

    function automatic logic [63:0] umin(logic [63:0] a, logic [63:0] b);
        return a < b ? a : b;
    endfunction

    function automatic logic [63:0] umax(logic [63:0] a, logic [63:0] b);
        return a > b ? a : b;
    endfunction

    // Predict the step sequence of one frame and queue it.
    task automatic predict_steps(input logic [TimeW-1:0] frame,
                                 input logic [TimeW-1:0] done_time,
                                 input logic [TimeW-1:0] prev, output int n_out);
        logic [63:0] f, mx, w, diff, s, t, wmin, wmax, lead, half, tts, e, up;
        bit ramp;
        int n;
        t_step_item it;
        f = 64'(frame);
        mx = (cfg_max != 0) ? cfg_max : 64'd1;
        wmin = 0; wmax = 0; lead = 0; half = 0;
        n = 0;
        n_out = 0;
        if (frame < done_time) return;
        w = (f > mx) ? f / (f / mx + 1) : f;
        diff = (w > 64'(prev)) ? w - 64'(prev) : 64'(prev) - w;
        ramp = diff > step_change(64'(prev));
        if (!ramp) begin
            wmin = (w << 16) / (64'd65536 + cfg_change);
            wmax = (w << 16) / (64'd65536 - cfg_change);
            if (wmax > TimeMask) wmax = TimeMask;
            lead = umin(cfg_lead, w / 5);
            half = lead >> 1;
        end
        s = 64'(prev);
        t = 64'(done_time);
        do begin
            if (ramp) begin
                if (w > s) s = umin(w, s + step_change(s));
                else s = umax(w, s - step_change(s));
            end else begin
                tts = f - t + lead;
                e = (s != 0) ? (s - tts % s) % s : 64'd0;
                if (e < s - e) begin
                    if (e > half) s = umax(wmin, s - umin(e, step_change(s)));
                end else begin
                    up = s - e;
                    if (up > half) s = umin(wmax, s + umin(up, step_change(s)));
                end
            end
            s &= TimeMask;
            t += s;
            n++;
            it.step = s[TimeW-1:0];
            it.last = !(t <= f && n < MaxSteps);
            it.trunc = it.last && (t <= f);
            step_queue.push_back(it);
        end while (t <= f && n < MaxSteps);
        n_out = n;
    endtask

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Register write over the config port; only called while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegChange: cfg_change = 64'(value & 32'hFFFF);
            RegLead:   cfg_lead = 64'(value) & TimeMask;
            default:   cfg_max = 64'(value) & TimeMask;
        endcase
    endtask

    // Offer one frame item and wait for it to be taken. The valid stays up
    // after the item is taken and is dropped by the next gap or by the drain.
    task automatic send_frame(input logic [TimeW-1:0] frame,
                              input logic [TimeW-1:0] done_time,
                              input logic [TimeW-1:0] prev, input int gap,
                              output int n_steps);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, prev, done_time, frame};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_steps(frame, done_time, prev, n_steps);
    endtask

    // Stop offering, drain all expected steps, then leave the block idle for
    // a while.
    task automatic drain_block;
        s_tvalid <= 1'b0;
        while (step_queue.size() != 0) @(posedge i_clk);
        wait_cycles(400);
    endtask

    function automatic logic [TimeW-1:0] rand_time();
        case ($urandom_range(0, 4))
            0: return TimeW'($urandom_range(0, 64));
            1: return TimeMax - TimeW'($urandom_range(0, 64));
            2: return TimeW'($urandom_range(100000, 700000));
            default: return TimeW'($urandom());
        endcase
    endfunction

    // Random frame: mostly a well-formed frame that covers some steps.
    task automatic send_random_frame;
        logic [TimeW-1:0] f, a, l;
        int n_steps;
        if ($urandom_range(0, 9) < 7) begin
            f = TimeW'($urandom_range(1000, 2000000));
            a = TimeW'($urandom_range(0, 20000));
            l = (cfg_max < 64'(f)) ? cfg_max[TimeW-1:0] : f;
            l = l + TimeW'($urandom_range(0, 2000)) - TimeW'(1000);
            if ($urandom_range(0, 3) == 0) l = TimeW'($urandom_range(1, 1000000));
        end else begin
            f = rand_time(); a = rand_time(); l = rand_time();
        end
        send_frame(f, a, l, int'($urandom_range(0, 7)), n_steps);
    endtask

    // Result side: random stall per item, plus one long hold-off.
    initial begin
        int stall;
        t_step_item exp_it;
        logic [TimeW-1:0] got_step;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 7));
            if (stall != 0 || hold_off) begin
                m_tready <= 1'b0;
                wait_cycles(stall);
                while (hold_off) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            got_step = m_tdata[TimeW-1:0];
            if (step_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected step item: step=%0d last=%b trunc=%b",
                             got_step, m_tlast, m_tuser);
            end else begin
                exp_it = step_queue.pop_front();
                if (got_step !== exp_it.step || m_tlast !== exp_it.last
                    || m_tuser !== exp_it.trunc || m_tdata[31:TimeW] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("step mismatch: expected %0d/%b/%b got %0d/%b/%b",
                                 exp_it.step, exp_it.last, exp_it.trunc,
                                 got_step, m_tlast, m_tuser);
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either stream.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n || hold_off)
            idle_cycles <= 0;
        else if (!stim_done || step_queue.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("physics_substep_scheduler verification failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        t_frame_row rows[$];
        t_frame_row r;
        int n_got;
        cfg_change = 64'(pss_pkg::ChangeRst);
        cfg_lead = 64'(pss_pkg::LeadRst);
        cfg_max = 64'(pss_pkg::MaxRst);
        wait_cycles(10);
        i_rst_n <= 1'b1;
        wait_cycles(2);

        // Directed table. Fixed rows: a covered frame gives nothing, and a
        // zero frame after a short step repeats that step once.
        rows.push_back('{25'd5, 25'd6, 25'd100, 0, 25'd0, 1'b0});
        rows.push_back('{25'd0, 25'd0, 25'd5, 1, 25'd5, 1'b0});
        rows.push_back('{25'd0, TimeMax, TimeMax, 0, 25'd0, 1'b0});
        rows.push_back('{TimeMax, TimeMax, TimeMax, -1, 25'd0, 1'b0});
        rows.push_back('{TimeMax, 25'd0, 25'd0, -1, 25'd0, 1'b0});
        rows.push_back('{TimeMax, 25'd0, TimeMax, -1, 25'd0, 1'b0});
        rows.push_back('{25'd100, 25'd0, 25'd0, -1, 25'd0, 1'b0});
        rows.push_back('{25'd279620, 25'd0, 25'd279620, -1, 25'd0, 1'b0});
        rows.push_back('{25'd279620, 25'd1000, 25'd200000, -1, 25'd0, 1'b0});
        rows.push_back('{25'd279620, 25'd0, 25'd400000, -1, 25'd0, 1'b0});
        rows.push_back('{25'd1342178, 25'd0, 25'd447392, -1, 25'd0, 1'b0});
        rows.push_back('{25'd1342178, 25'd5000, 25'd447000, -1, 25'd0, 1'b0});
        rows.push_back('{25'd671089, 25'd671089, 25'd671089, -1, 25'd0, 1'b0});
        rows.push_back('{25'd671090, 25'd0, 25'd335545, -1, 25'd0, 1'b0});
        rows.push_back('{25'h0AAAAAA, 25'h0555555, 25'h1555555, -1, 25'd0, 1'b0});
        rows.push_back('{25'h1555555, 25'h0AAAAAA, 25'h0AAAAAA, -1, 25'd0, 1'b0});
        foreach (rows[i]) begin
            r = rows[i];
            send_frame(r.frame, r.done_time, r.prev, int'($urandom_range(0, 7)), n_got);
            if (r.fixed_n >= 0 && (n_got != r.fixed_n
                || (r.fixed_n == 1 && (step_queue[$].step != r.fixed_step
                || step_queue[$].trunc != r.fixed_trunc)))) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: expected %0d steps, model gives %0d",
                             i, r.fixed_n, n_got);
            end
        end
        drain_block();

        // Zero step on a long frame with zero change fraction: stuck zero step.
        write_reg(RegChange, 32'd0);
        send_frame(25'd1000, 25'd0, 25'd0, 0, n_got);
        if (n_got != MaxSteps || !step_queue[$].trunc) begin
            mismatches++;
            if (mismatches <= 10)
                $display("step cap row: expected %0d steps ending truncated, got %0d",
                         MaxSteps, n_got);
        end
        drain_block();

        // Random phases over several register settings, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(RegChange, 32'hFFFF);
                    write_reg(RegLead, 32'(TimeMax));
                    write_reg(RegMax, 32'd0);
                end
                1: begin
                    write_reg(RegChange, 32'd1311);
                    write_reg(RegLead, 32'd0);
                    write_reg(RegMax, 32'(TimeMax));
                end
                2: begin
                    write_reg(RegChange, $urandom_range(0, 65535));
                    write_reg(RegLead, $urandom() & 32'h1FF_FFFF);
                    write_reg(RegMax, $urandom_range(1, 2000000));
                end
                3: begin
                    write_reg(RegChange, 32'd6553);
                    write_reg(RegLead, 32'd50332);
                    write_reg(RegMax, 32'd1);
                end
                default: begin
                    write_reg(RegChange, 32'(pss_pkg::ChangeRst));
                    write_reg(RegLead, 32'(pss_pkg::LeadRst));
                    write_reg(RegMax, 32'(pss_pkg::MaxRst));
                end
            endcase
            // Long receiver hold-off in the first phase; the input stalls.
            if (ph == 0) begin
                fork
                    begin
                        hold_off = 1'b1;
                        wait_cycles(3000);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (NumRandom / 5) send_random_frame();
            drain_block();
        end

        stim_done = 1'b1;
        if (mismatches == 0 && step_queue.size() == 0)
            $display("physics_substep_scheduler verification clean");
        else
            $display("physics_substep_scheduler verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/pss_pkg.sv
sv/pss_div.sv
sv/physics_substep_scheduler.sv
tb/sv/physics_substep_scheduler_test.sv
